/* sv/rise_glitch_detector_assert.svh */
// assertion macros for the rise glitch detector
`ifndef RISE_GLITCH_DETECTOR_ASSERT_SVH
`define RISE_GLITCH_DETECTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rise_glitch_detector: implication check failed");

// next-cycle implication, checked out of reset
`define RGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rise_glitch_detector: next-cycle check failed");

`endif

/* sv/rgd_pkg.sv */
// shared types and constants for the rise glitch detector
package rgd_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned MinSizeW = 31;
  localparam int unsigned KeepW    = 5;
  localparam int unsigned SkipW    = 4;
  localparam int unsigned MaxKeep  = 16;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_GLITCH_SIZE = 1'b0,
    CFG_KEEP_EVERY      = 1'b1
  } cfg_idx_t;

  typedef logic [DataW-1:0] word_t;

endpackage

/* sv/rise_glitch_detector.sv */
// rise glitch detector: decimation, rise tracking and glitch reporting
// an input transfer reaches the result through two registers: the input register, then the result register
// one sample per cycle while the result register is not stalled; the state update sits between the two registers
// a stalled result register holds the input register, which then stalls the input
// reset (rst_n low, synchronous) clears valids, run control state, the previous sample and config to 0 / keep_every 1
// config writes are always ready and must only happen while the block is idle
module rise_glitch_detector
  import rgd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // sample channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DataW-1:0]          in_sample_time,
  input  logic signed [DataW-1:0]   in_sample_value,
  input  logic                      in_run_start,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DataW-1:0]          out_glitch_time,
  output logic [DataW-1:0]          out_rise_time,
  output logic [DataW-1:0]          out_jump_size,
  output logic [DataW-1:0]          out_wait_time,
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [DataW-1:0]          cfg_data
);

`include "rise_glitch_detector_assert.svh"

  // config registers
  logic [MinSizeW-1:0] min_size_r;
  logic [KeepW-1:0]    keep_every_r;

  // input register
  logic              s1_vld_r;
  word_t             s1_time_r;
  logic signed [DataW-1:0] s1_value_r;
  logic              s1_start_r;

  // run state
  word_t             prev_time_r, prev_time_nxt;
  logic signed [DataW-1:0] prev_value_r, prev_value_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic              rising_r, rising_nxt;
  word_t             rise_t_r, rise_t_nxt;
  logic signed [DataW-1:0] rise_v_r, rise_v_nxt;
  word_t             last_glitch_r, last_glitch_nxt;
  logic              have_glitch_r, have_glitch_nxt;
  logic [SkipW-1:0]  skip_r, skip_nxt;

  // result register
  logic  out_vld_r;
  word_t glitch_time_r, rise_time_r, jump_size_r, wait_time_r;
  word_t glitch_time_nxt, rise_time_nxt, jump_size_nxt, wait_time_nxt;

  logic              s1_go;
  logic              emit;
  logic [KeepW-1:0]  n_eff;
  logic [KeepW-1:0]  skip_inc;
  logic              keep;
  logic              cur_have_prev, cur_rising, cur_have_glitch;
  logic [SkipW-1:0]  cur_skip;
  logic              slope_up, slope_down;
  logic signed [DataW:0] rise_size;

  // the input register moves on when the result slot is free or being drained
  assign s1_go     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !s1_go;
  assign cfg_ready = 1'b1;

  // decimation factor, clamped to 1..16
  always_comb begin
    if (keep_every_r == '0) begin
      n_eff = KeepW'(1);
    end else if (keep_every_r > KeepW'(MaxKeep)) begin
      n_eff = KeepW'(MaxKeep);
    end else begin
      n_eff = keep_every_r;
    end
  end

  // single pass over one sample: run clear, decimation, slope, glitch check
  always_comb begin
    // a run start sees a cleared run
    cur_have_prev   = have_prev_r && !s1_start_r;
    cur_rising      = rising_r && !s1_start_r;
    cur_have_glitch = have_glitch_r && !s1_start_r;
    cur_skip        = s1_start_r ? '0 : skip_r;

    keep     = (cur_skip == '0);
    skip_inc = {1'b0, cur_skip} + KeepW'(1);
    skip_nxt = (skip_inc >= n_eff) ? '0 : skip_inc[SkipW-1:0];

    slope_up   = s1_value_r > prev_value_r;
    slope_down = s1_value_r < prev_value_r;

    prev_time_nxt   = prev_time_r;
    prev_value_nxt  = prev_value_r;
    have_prev_nxt   = cur_have_prev;
    rising_nxt      = cur_rising;
    rise_t_nxt      = rise_t_r;
    rise_v_nxt      = rise_v_r;
    last_glitch_nxt = last_glitch_r;
    have_glitch_nxt = cur_have_glitch;
    emit            = 1'b0;

    // a rise starting on this sample cannot also end on it, so the peak is prev
    rise_size = {prev_value_r[DataW-1], prev_value_r} - {rise_v_r[DataW-1], rise_v_r};

    glitch_time_nxt = rise_t_r;
    rise_time_nxt   = prev_time_r - rise_t_r;
    jump_size_nxt   = rise_size[DataW-1:0];
    wait_time_nxt   = rise_t_r - last_glitch_r;

    if (keep) begin
      if (cur_have_prev) begin
        if (!cur_rising && slope_up) begin
          rising_nxt = 1'b1;
          rise_t_nxt = prev_time_r;
          rise_v_nxt = prev_value_r;
        end
        if (cur_rising && slope_down) begin
          if (rise_size > $signed({2'b00, min_size_r})) begin
            emit            = cur_have_glitch;
            last_glitch_nxt = rise_t_r;
            have_glitch_nxt = 1'b1;
          end
          rising_nxt = 1'b0;
        end
      end
      prev_time_nxt  = s1_time_r;
      prev_value_nxt = s1_value_r;
      have_prev_nxt  = 1'b1;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r   <= '0;
      keep_every_r <= KeepW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_GLITCH_SIZE: min_size_r   <= cfg_data[MinSizeW-1:0];
        CFG_KEEP_EVERY:      keep_every_r <= cfg_data[KeepW-1:0];
        default:             ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_time_r  <= in_sample_time;
      s1_value_r <= in_sample_value;
      s1_start_r <= in_run_start;
    end
  end

  // run state: control bits and the previous sample reset, rise and glitch datapath held until a rise or glitch sets it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r   <= 1'b0;
      rising_r      <= 1'b0;
      have_glitch_r <= 1'b0;
      skip_r        <= '0;
      prev_value_r  <= '0;
      prev_time_r   <= '0;
    end else if (s1_go) begin
      have_prev_r   <= have_prev_nxt;
      rising_r      <= rising_nxt;
      have_glitch_r <= have_glitch_nxt;
      skip_r        <= skip_nxt;
      prev_value_r  <= prev_value_nxt;
      prev_time_r   <= prev_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      rise_t_r      <= rise_t_nxt;
      rise_v_r      <= rise_v_nxt;
      last_glitch_r <= last_glitch_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= emit;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      glitch_time_r <= glitch_time_nxt;
      rise_time_r   <= rise_time_nxt;
      jump_size_r   <= jump_size_nxt;
      wait_time_r   <= wait_time_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_glitch_time = glitch_time_r;
  assign out_rise_time   = rise_time_r;
  assign out_jump_size   = jump_size_r;
  assign out_wait_time   = wait_time_r;

  // checks
  `RGD_ASSERT_IMPL(a_rising_needs_prev, clk, rst_n, rising_r, have_prev_r)
  `RGD_ASSERT_IMPL(a_emit_needs_glitch, clk, rst_n, s1_go && emit, have_glitch_r)
  `RGD_ASSERT_NEXT(a_result_from_pass, clk, rst_n, !out_vld_r && !s1_go, !out_vld_r)
  `RGD_ASSERT_NEXT(a_held_sample, clk, rst_n, s1_vld_r && !s1_go,
                   s1_vld_r && $stable(s1_time_r) && $stable(s1_value_r))

endmodule

/* sim/testbench.sv */
// testbench for rise_glitch_detector: random stimulus, model-based checking of every result
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rgd_pkg::*;

  localparam int     ResetCycles   = 11;
  localparam int     SettleCycles  = 8;       // well beyond the two-stage pipeline
  localparam int     DrainLimit    = 5000;    // cycles allowed for outstanding results
  localparam int     HoldOffCycles = 300;     // long receiver hold-off to back up the pipe
  localparam int     CycleLimit    = 600000;
  localparam int     MaxReports    = 50;
  localparam longint ValueMax      = 64'sd2147483647;
  localparam longint ValueMin      = -64'sd2147483648;

  typedef struct packed {
    word_t sample_time;
    word_t sample_value;
    logic  run_start;
  } sample_t;

  typedef struct packed {
    word_t glitch_time;
    word_t rise_time;
    word_t jump_size;
    word_t wait_time;
  } glitch_t;

  // clock, reset and block ports; the ones driven here are known from time zero
  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [DataW-1:0]        in_sample_time  = '0;
  logic signed [DataW-1:0] in_sample_value = '0;
  logic                    in_run_start    = 1'b0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [DataW-1:0]        out_glitch_time;
  logic [DataW-1:0]        out_rise_time;
  logic [DataW-1:0]        out_jump_size;
  logic [DataW-1:0]        out_wait_time;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index       = '0;
  logic [DataW-1:0]        cfg_data        = '0;

  // samples waiting for the driver, and the glitch reports the detector owes us
  sample_t pending_samples[$];
  glitch_t expected_glitches[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off_req = 1'b0;
  int hold_count = 0;
  int cycle_count = 0;
  int fail_count = 0;
  sample_t next_sample;

  // predictor copy of the configuration registers
  logic [MinSizeW-1:0] min_size_reg = '0;
  logic [KeepW-1:0]    keep_reg     = KeepW'(1);

  // predictor copy of the per-run tracking state
  word_t                   last_time     = '0;
  logic signed [DataW-1:0] last_value    = '0;
  logic                    have_last     = 1'b0;
  logic                    in_rise       = 1'b0;
  word_t                   rise_from_time = '0;
  logic signed [DataW-1:0] rise_from_value = '0;
  word_t                   prev_glitch_time = '0;
  logic                    seen_glitch   = 1'b0;
  int unsigned             skip_pos      = 0;

  rise_glitch_detector DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .in_run_start    (in_run_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glitch_time (out_glitch_time),
    .out_rise_time   (out_rise_time),
    .out_jump_size   (out_jump_size),
    .out_wait_time   (out_wait_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxReports) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input word_t got, input word_t want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // advance the glitch tracker by one accepted sample and queue any report it owes
  task automatic track_sample(input sample_t s);
    int unsigned keep_n;
    logic keep_now;
    logic signed [DataW-1:0] v_now;
    longint slope;
    longint rise_size;
    glitch_t g;
    keep_n = keep_reg;
    // a factor of zero behaves as one, anything above sixteen as sixteen
    if (keep_n == 0) keep_n = 1;
    else if (keep_n > MaxKeep) keep_n = MaxKeep;
    v_now = s.sample_value;
    if (s.run_start) begin
      last_time        = '0;
      last_value       = '0;
      have_last        = 1'b0;
      in_rise          = 1'b0;
      rise_from_time   = '0;
      rise_from_value  = '0;
      prev_glitch_time = '0;
      seen_glitch      = 1'b0;
      skip_pos         = 0;
    end
    keep_now = (skip_pos == 0);
    skip_pos = (skip_pos + 1 >= keep_n) ? 0 : skip_pos + 1;
    if (keep_now) begin
      if (have_last) begin
        // only the sign of the value step matters, times never do
        slope = longint'(v_now) - longint'(last_value);
        if (!in_rise && slope > 0) begin
          in_rise         = 1'b1;
          rise_from_time  = last_time;
          rise_from_value = last_value;
        end
        if (in_rise && slope < 0) begin
          // the previous kept sample is the peak
          rise_size = longint'(last_value) - longint'(rise_from_value);
          if (rise_size > longint'(min_size_reg)) begin
            if (seen_glitch) begin
              g.glitch_time = rise_from_time;
              g.rise_time   = last_time - rise_from_time;
              g.jump_size   = word_t'(rise_size);
              g.wait_time   = rise_from_time - prev_glitch_time;
              expected_glitches = {expected_glitches, g};
            end
            prev_glitch_time = rise_from_time;
            seen_glitch      = 1'b1;
          end
          in_rise = 1'b0;
        end
      end
      last_time  = s.sample_time;
      last_value = v_now;
      have_last  = 1'b1;
    end
  endtask

  // driver: a new sample only once the current one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_samples.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        next_sample = pending_samples.pop_front();
        in_valid        <= 1'b1;
        in_sample_time  <= next_sample.sample_time;
        in_sample_value <= next_sample.sample_value;
        in_run_start    <= next_sample.run_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off once requested so the input backs up
  always @(posedge clk) begin
    if (hold_off_req && hold_count < HoldOffCycles) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
    end
  end

  // monitor: check the result transfer first, then feed the input transfer to the predictor
  always @(posedge clk) begin
    glitch_t want;
    sample_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_glitches.size() == 0) begin
          report_mismatch($sformatf("unexpected result time %h size %h",
                                    out_glitch_time, out_jump_size));
        end else begin
          want = expected_glitches.pop_front();
          check_field("glitch_time", out_glitch_time, want.glitch_time);
          check_field("rise_time",   out_rise_time,   want.rise_time);
          check_field("jump_size",   out_jump_size,   want.jump_size);
          check_field("wait_time",   out_wait_time,   want.wait_time);
        end
      end
      if (in_valid && !in_stall) begin
        seen.sample_time  = in_sample_time;
        seen.sample_value = in_sample_value;
        seen.run_start    = in_run_start;
        track_sample(seen);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // register write over the config channel; the predictor follows at the transfer
  task automatic write_reg(input cfg_idx_t idx, input word_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MIN_GLITCH_SIZE) min_size_reg = data[MinSizeW-1:0];
    else keep_reg = data[KeepW-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input word_t t, input word_t v, input logic s);
    sample_t item;
    item = '{t, v, s};
    pending_samples = {pending_samples, item};
  endtask

  // mostly small steps, sometimes equal stamps or big jumps that wrap
  function automatic word_t next_stamp(input word_t t);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return t;
    if (pick < 8) return t + word_t'($urandom);
    return t + word_t'($urandom_range(1000, 1));
  endfunction

  // well-formed runs of rises and falls sized around the threshold, plus noise
  task automatic queue_stimulus(input int points);
    int unsigned keep_n;
    int run_len;
    int added;
    int k;
    int j;
    int pick;
    longint level;
    longint delta;
    word_t stamp;
    logic opening;
    keep_n = keep_reg;
    if (keep_n == 0) keep_n = 1;
    else if (keep_n > MaxKeep) keep_n = MaxKeep;
    added = 0;
    stamp = $urandom;
    level = longint'($signed($urandom));
    while (added < points) begin
      if ($urandom_range(99) < 8) begin
        // noise, occasionally breaking a run with a stray run start
        push_sample($urandom, $urandom, $urandom_range(7) == 0);
        added++;
      end else begin
        opening = ($urandom_range(4) != 0);
        run_len = $urandom_range(16, 4);
        for (k = 0; k < run_len; k++) begin
          pick = $urandom_range(99);
          if (pick < 10) begin
            // swing to a rail so the largest rises occur
            level = $urandom_range(1) ? ValueMax - $urandom_range(3)
                                      : ValueMin + $urandom_range(3);
          end else if (pick >= 25) begin
            case ($urandom_range(2))
              0:       delta = $urandom_range(1000, 1);
              1:       delta = longint'(min_size_reg) + $urandom_range(4) - 2;
              default: delta = $urandom;
            endcase
            level = $urandom_range(1) ? level + delta : level - delta;
            if (level > ValueMax) level = ValueMax;
            if (level < ValueMin) level = ValueMin;
          end
          // pick below 25 and not a swing: flat, state must hold
          push_sample(stamp, word_t'(level), opening && k == 0);
          // samples dropped by decimation carry arbitrary values
          for (j = 1; j < keep_n; j++) begin
            stamp = next_stamp(stamp);
            push_sample(stamp, $urandom, 1'b0);
          end
          stamp = next_stamp(stamp);
        end
        added += run_len;
      end
    end
  endtask

  // let everything queued transfer and every owed result come back
  task automatic drain;
    int waited;
    do @(negedge clk); while (pending_samples.size() != 0 || in_valid);
    waited = 0;
    while (expected_glitches.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk);
    if (expected_glitches.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_glitches.size()));
      expected_glitches.delete();
    end
  endtask

  initial begin
    word_t phase_min[8];
    word_t phase_keep[8];
    int phase_send[8];
    int phase_recv[8];
    int phase_points[8];
    int p;

    phase_min    = '{32'd0, 32'h7FFF_FFFF, 32'd1000, 32'd0,
                     32'h0001_0000, 32'd5, 32'd0, 32'hFFFF_FFFF};
    phase_keep   = '{32'd1, 32'd1, 32'd0, 32'd3,
                     32'd16, 32'd31, 32'd2, 32'hFFFF_FFE5};
    phase_send   = '{0, 72, 0, 35, 0, 35, 72, 0};
    phase_recv   = '{0, 0, 72, 35, 0, 35, 0, 72};
    // sized so the whole run sends about eleven hundred samples after decimation padding
    phase_points = '{120, 120, 120, 40, 8, 8, 50, 20};

    phase_min[3] = $urandom_range(32'h7FFF_FFFF);
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset configuration: threshold 0, every sample kept
    push_sample(32'd0, 32'd0, 1'b0);                   // no run start seen yet
    push_sample(32'd5, 32'h8000_0000, 1'b0);           // fall to the lowest value
    push_sample(32'd5, 32'h8000_0000, 1'b0);           // repeated stamp, flat value
    push_sample(32'd10, 32'h7FFF_FFFF, 1'b0);          // full-scale rise
    push_sample(32'd10, 32'h7FFF_FFFF, 1'b0);          // flat at the peak keeps rising
    push_sample(32'd20, 32'd0, 1'b0);                  // first glitch, only remembered
    push_sample(32'd30, 32'd100, 1'b0);
    push_sample(32'd40, 32'd50, 1'b0);                 // second glitch is reported
    push_sample(32'hFFFF_FFF0, 32'd0, 1'b0);
    push_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'd3, 32'hFFFF_FFFF, 1'b0);           // stamp wraps after the peak
    push_sample(32'd1, 32'd5, 1'b0);                   // stamps going backwards
    push_sample(32'd0, 32'd4, 1'b0);
    push_sample(32'd100, 32'd1000, 1'b1);              // new run clears history
    push_sample(32'd101, 32'd2000, 1'b0);
    push_sample(32'd102, 32'd1500, 1'b0);
    push_sample(32'd103, 32'd3000, 1'b0);
    push_sample(32'd104, 32'd0, 1'b0);
    push_sample(32'd7, 32'hFFFF_FFFB, 1'b1);           // back-to-back run starts
    push_sample(32'd8, 32'hFFFF_FFFB, 1'b1);
    push_sample(32'd9, 32'd1, 1'b0);
    push_sample(32'd9, 32'd0, 1'b0);
    drain();

    // random phases over threshold and decimation settings and idling mixes
    for (p = 0; p < 8; p++) begin
      write_reg(CFG_MIN_GLITCH_SIZE, phase_min[p]);
      write_reg(CFG_KEEP_EVERY, phase_keep[p]);
      @(negedge clk);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      // low threshold, no idling: results are dense, so the hold-off backs up the input
      if (p == 0) hold_off_req = 1'b1;
      queue_stimulus(phase_points[p]);
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
